/* rtl/dq_pkg.sv */
package dq_pkg;

  localparam int DATA_W = 32;

  // Operation codes carried in the input word
  localparam logic [2:0] OP_INS_FRONT = 3'd0;
  localparam logic [2:0] OP_INS_BACK  = 3'd1;
  localparam logic [2:0] OP_REM_FRONT = 3'd2;
  localparam logic [2:0] OP_REM_BACK  = 3'd3;
  localparam logic [2:0] OP_LIST      = 3'd4;

  // Status codes carried in the result word
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // What every cell of the chain does, as chosen by the broadcast mode
  typedef enum logic [2:0] {
    CM_HOLD,       // keep the stored value
    CM_SHIFT_IN,   // insert at front: cell 0 loads, others take left neighbor
    CM_PUT_BACK,   // insert at back: the cell at the fill level loads
    CM_SHIFT_OUT,  // remove from front: every cell takes right neighbor
    CM_ROTATE      // listing: occupied cells rotate toward the head
  } cell_mode_t;

  typedef struct packed {
    logic [2:0]               op;
    logic signed [DATA_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [DATA_W-1:0] item;
    logic                     last;
  } out_word_t;

endpackage

/* rtl/dq_cell.sv */
module dq_cell import dq_pkg::*; #(
  parameter int IDX = 0,
  parameter int CW  = 5
) (
  input  logic                     clk,
  input  cell_mode_t               mode,
  input  logic [CW-1:0]            cnt,
  input  logic signed [DATA_W-1:0] ext_val,
  input  logic signed [DATA_W-1:0] left_val,
  input  logic signed [DATA_W-1:0] right_val,
  output logic signed [DATA_W-1:0] val
);

  localparam logic [CW-1:0] MY_POS  = CW'(IDX);
  localparam logic [CW-1:0] NXT_POS = CW'(IDX + 1);

  logic signed [DATA_W-1:0] val_r;
  logic signed [DATA_W-1:0] val_nxt;

  // local choice of the next value from the broadcast mode
  always_comb begin
    val_nxt = val_r;
    case (mode)
      CM_SHIFT_IN:  val_nxt = (IDX == 0) ? ext_val : left_val;
      CM_PUT_BACK:  if (cnt == MY_POS) val_nxt = ext_val;
      CM_SHIFT_OUT: val_nxt = right_val;
      CM_ROTATE: begin
        // tail of the occupied run takes the old head
        if (cnt == NXT_POS) val_nxt = ext_val;
        else if (NXT_POS < cnt) val_nxt = right_val;
      end
      default: val_nxt = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val = val_r;

endmodule

/* rtl/double_ended_queue_core.sv */
// Double-ended queue of signed 32-bit words, built as a chain of DEPTH cells.
// Input channel: in_word (op, value) is taken at a rising edge where start is
// high and busy is low. Ops: insert front, insert back, remove front, remove
// back, list.
// Result channel: out_word (status, item, last) is valid for exactly one cycle
// while out_strobe is high; the receiver cannot stall it, and must take every
// word as it comes.
// Inserts and removals: one result, registered and shown in the cycle after
// acceptance; busy stays low, so a new word may be taken every cycle.
// List of N stored words: N results on consecutive cycles, the last marked.
// Acceptance enters the listing state, which registers each result from the
// head; busy stays high. The chain rotates one cell per cycle and ends in its
// original order. Listing an empty queue gives one empty result.
// Insert into a full queue gives status full; removal from empty gives empty.
// Unused op codes give no result.
// Reset (rst_n low, synchronous) empties the queue and drops a listing in
// progress; cell contents are left as they are and are never read unwritten.
module double_ended_queue_core import dq_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_word_t  in_word,
  output logic      out_strobe,
  output out_word_t out_word
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
  localparam logic [CW-1:0] ONE_CNT  = CW'(1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_LIST = 1'b1;

  logic                     state_r, state_nxt;
  logic [CW-1:0]            cnt_r, cnt_nxt;
  logic [CW-1:0]            rem_r, rem_nxt;
  logic                     strobe_r, strobe_nxt;
  out_word_t                out_r, out_nxt;
  cell_mode_t               mode;
  logic signed [DATA_W-1:0] ext_val;
  logic signed [DATA_W-1:0] cell_val [DEPTH];
  logic                     accept;
  logic                     full;
  logic                     empty;

  assign busy   = (state_r == ST_LIST);
  assign accept = start && !busy;
  assign full   = (cnt_r == FULL_CNT);
  assign empty  = (cnt_r == '0);

  // sequencing of the chain and the result word
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    rem_nxt        = rem_r;
    strobe_nxt     = 1'b0;
    out_nxt.status = ST_OK;
    out_nxt.item   = '0;
    out_nxt.last   = 1'b1;
    mode           = CM_HOLD;
    ext_val        = in_word.value;
    if (state_r == ST_LIST) begin
      mode         = CM_ROTATE;
      ext_val      = cell_val[0];
      strobe_nxt   = 1'b1;
      out_nxt.item = cell_val[0];
      out_nxt.last = (rem_r == ONE_CNT);
      rem_nxt      = rem_r - ONE_CNT;
      if (rem_r == ONE_CNT) state_nxt = ST_IDLE;
    end else if (accept) begin
      unique case (in_word.op) inside
        OP_INS_FRONT, OP_INS_BACK: begin
          strobe_nxt = 1'b1;
          if (full) begin
            out_nxt.status = ST_FULL;
          end else begin
            mode    = (in_word.op == OP_INS_FRONT) ? CM_SHIFT_IN : CM_PUT_BACK;
            cnt_nxt = cnt_r + ONE_CNT;
          end
        end
        OP_REM_FRONT, OP_REM_BACK: begin
          strobe_nxt = 1'b1;
          if (empty) begin
            out_nxt.status = ST_EMPTY;
          end else begin
            if (in_word.op == OP_REM_FRONT) mode = CM_SHIFT_OUT;
            cnt_nxt = cnt_r - ONE_CNT;
          end
        end
        OP_LIST: begin
          if (empty) begin
            strobe_nxt     = 1'b1;
            out_nxt.status = ST_EMPTY;
          end else begin
            state_nxt = ST_LIST;
            rem_nxt   = cnt_r;
          end
        end
        default: begin
          strobe_nxt = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      cnt_r    <= '0;
      rem_r    <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      rem_r    <= rem_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  // result payload needs no reset
  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_strobe = strobe_r;
  assign out_word   = out_r;

  // the chain of storage cells
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [DATA_W-1:0] left_val;
    logic signed [DATA_W-1:0] right_val;
    if (g == 0) begin : g_first
      assign left_val = '0;
    end else begin : g_mid_l
      assign left_val = cell_val[g-1];
    end
    if (g == DEPTH - 1) begin : g_end
      assign right_val = '0;
    end else begin : g_mid_r
      assign right_val = cell_val[g+1];
    end
    dq_cell #(
      .IDX (g),
      .CW  (CW)
    ) u_cell (
      .clk       (clk),
      .mode      (mode),
      .cnt       (cnt_r),
      .ext_val   (ext_val),
      .left_val  (left_val),
      .right_val (right_val),
      .val       (cell_val[g])
    );
  end

  // fill level never passes the chain length
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FULL_CNT)
    else $error("fill level above depth");

  // a listing only runs over a non-empty queue with words left to send
  a_list_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> (!empty && rem_r != '0 && rem_r <= cnt_r))
    else $error("listing over empty queue");

  // end of a listing comes with the marked final word
  a_list_end: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> (out_strobe && out_word.last))
    else $error("listing ended without final word");

  // an unmarked word only appears inside a listing
  a_unmarked: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_word.last) |-> busy)
    else $error("unmarked word outside listing");

endmodule
